>>> rtl/jcsl_pkg.sv
// Package for the joint command slew limiter: payload types, constants, register indexes.
package jcsl_pkg;

   localparam int NUM_JOINTS  = 8;
   localparam int FRAC_BITS   = 16;
   localparam int GAP_GAIN    = 10;
   // |v| < 1e-6 rad/s in fixed point: ceil(2^FRAC_BITS / 1e6) LSBs
   localparam int ZERO_THRESH = ((1 << FRAC_BITS) + 999999) / 1000000;

   localparam int JIDX_W   = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DAT_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_WRITE_ENABLE    = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_CONTROL_RATE_HZ = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_STEP        = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SPEED       = CSR_IDX_W'(3);

   typedef struct packed {
      logic [2:0]         joint_index;
      logic signed [31:0] position_command;
      logic signed [31:0] measured_position;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]         joint_out;
      logic signed [31:0] limited_command;
      logic signed [31:0] vel_target;
      logic               step_was_limited;
   } rsp_payload_type;

   // Stage-one result handed to the velocity stage
   typedef struct packed {
      logic [2:0]         joint;
      logic signed [31:0] lim;
      logic signed [32:0] step;
      logic signed [32:0] gap;
      logic               limited;
   } mid_type;

endpackage

>>> rtl/joint_command_slew_limiter_top.sv
// Joint command slew limiter top level: step limit, velocity target and clamp per joint.
// An accepted req beat moves through the input, stage and result registers before rsp_valid
// rises; it then leaves the result register once rsp_stall is low.
// Throughput: one beat per cycle unless stalled, set by the per-joint command update.
// Reset: synchronous, active high; clears pipeline valids, loads register defaults and
// zeroes every stored previous command at once.
module joint_command_slew_limiter_top import jcsl_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_payload_type      req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_payload_type      rsp_payload,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data
);

   localparam int VEL_W = 48;
   localparam logic signed [VEL_W-1:0] ZT_S   = VEL_W'(ZERO_THRESH);
   localparam logic signed [VEL_W-1:0] GAIN_S = VEL_W'(GAP_GAIN);

   // ---------------- configuration registers ----------------
   logic        write_enable_ff;
   logic [13:0] control_rate_hz_ff;
   logic [30:0] max_step_ff;
   logic [30:0] max_speed_ff;

   // Accept every write beat; indexes beyond the list are dropped.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         write_enable_ff    <= 1'b1;
         control_rate_hz_ff <= 14'd1000;
         max_step_ff        <= 31'd6554;
         max_speed_ff       <= 31'd65536;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_WRITE_ENABLE:    write_enable_ff    <= csr_data[0];
            CSR_CONTROL_RATE_HZ: control_rate_hz_ff <= csr_data[13:0];
            CSR_MAX_STEP:        max_step_ff        <= csr_data[30:0];
            CSR_MAX_SPEED:       max_speed_ff       <= csr_data[30:0];
            default: ;
         endcase
      end
   end

   // ---------------- pipeline control ----------------
   // Three slots: input register, stage register, result register. A slot can
   // take a new beat when it is empty or its own content moves on this cycle.
   logic in_valid_ff, mid_valid_ff, out_valid_ff;
   logic out_free, mid_free, in_free;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign mid_free  = !mid_valid_ff || out_free;
   assign in_free   = !in_valid_ff || mid_free;
   assign req_stall = !in_free;
   assign rsp_valid = out_valid_ff;

   // Drop beats while writes are disabled or for joints that do not exist.
   logic req_keep;
   assign req_keep = write_enable_ff && (32'(req_payload.joint_index) < NUM_JOINTS);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         mid_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (in_free)  in_valid_ff  <= req_valid && req_keep;
         if (mid_free) mid_valid_ff <= in_valid_ff;
         if (out_free) out_valid_ff <= mid_valid_ff;
      end
   end

   // ---------------- input register ----------------
   req_payload_type in_ff;

   always_ff @(posedge clock) begin
      if (in_free) in_ff <= req_payload;
   end

   // ---------------- stage one: step limit ----------------
   logic signed [31:0] prev_ff [NUM_JOINTS];
   logic [JIDX_W-1:0]  in_jidx;
   logic signed [31:0] prev;
   logic signed [32:0] change, stp_s, lim_wide;
   logic [32:0]        abs_change;
   mid_type            mid_in, mid_ff;

   assign in_jidx = JIDX_W'(in_ff.joint_index);
   assign prev    = prev_ff[in_jidx];

   always_comb begin
      change     = 33'(in_ff.position_command) - 33'(prev);
      stp_s      = $signed({2'b00, max_step_ff});
      abs_change = change[32] ? 33'(-change) : 33'(change);

      mid_in.joint   = in_ff.joint_index;
      mid_in.limited = abs_change > {2'b00, max_step_ff};
      // Clip the move to previous +/- max_step; the result always fits 32 bits.
      lim_wide       = change[32] ? (33'(prev) - stp_s) : (33'(prev) + stp_s);
      mid_in.lim     = mid_in.limited ? 32'(lim_wide) : in_ff.position_command;
      mid_in.step    = mid_in.limited ? (change[32] ? -stp_s : stp_s) : change;
      mid_in.gap     = 33'(mid_in.lim) - 33'(in_ff.measured_position);
   end

   // Commit the new previous command as the beat leaves the input register, so
   // a following beat to the same joint sees it in the very next cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_JOINTS; i++) prev_ff[i] <= '0;
      end else if (in_valid_ff && mid_free) begin
         prev_ff[in_jidx] <= mid_in.lim;
      end
   end

   always_ff @(posedge clock) begin
      if (mid_free) mid_ff <= mid_in;
   end

   // ---------------- stage two: velocity target and clamp ----------------
   logic signed [VEL_W-1:0] vel_rate, vel_gap, vel_sel, spd_s;
   logic signed [31:0]      vel_clamped;
   logic                    vel_is_zero;
   rsp_payload_type         out_ff;

   always_comb begin
      // step * rate: 33-bit signed by 15-bit signed fits 48 bits exactly
      vel_rate    = VEL_W'(mid_ff.step) * VEL_W'($signed({1'b0, control_rate_hz_ff}));
      vel_gap     = VEL_W'(mid_ff.gap) * GAIN_S;
      vel_is_zero = (vel_rate > -ZT_S) && (vel_rate < ZT_S);
      // Fall back to the position gap when the slewed velocity rounds to zero.
      vel_sel     = vel_is_zero ? vel_gap : vel_rate;
      spd_s       = $signed({17'd0, max_speed_ff});
      if (vel_sel > spd_s) begin
         vel_clamped = 32'(spd_s);
      end else if (vel_sel < -spd_s) begin
         vel_clamped = 32'(-spd_s);
      end else begin
         vel_clamped = 32'(vel_sel);
      end
   end

   // Result register: hold while the consumer stalls.
   always_ff @(posedge clock) begin
      if (out_free) begin
         out_ff.joint_out        <= mid_ff.joint;
         out_ff.limited_command  <= mid_ff.lim;
         out_ff.vel_target       <= vel_clamped;
         out_ff.step_was_limited <= mid_ff.limited;
      end
   end

   assign rsp_payload = out_ff;

`ifndef SYNTH
   // The stored command for a joint matches the beat that just advanced.
   a_prev_commit: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && mid_free |=> prev_ff[JIDX_W'(mid_ff.joint)] == mid_ff.lim)
      else $error("previous command not committed");

   // A stage beat with a free consumer reaches the result register next cycle.
   a_mid_advance: assert property (@(posedge clock) disable iff (reset)
      mid_valid_ff && !rsp_stall |=> out_valid_ff)
      else $error("stage beat lost");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");
`endif

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the joint command slew limiter top level.
`timescale 1ns / 1ps

module tb_top;
   import jcsl_pkg::*;

   // Index with no register behind it; a write there must be taken and ignored.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_IDX = CSR_IDX_W'(9);

   localparam int     CLOCK_HALF     = 6;
   localparam int     DRAIN_CYCLES   = 8;     // pipeline is 3 deep; give it margin
   localparam int     WATCHDOG_LIMIT = 2000;  // far longer than any legal quiet stretch
   localparam int     RANDOM_PHASES  = 10;
   localparam int     PHASE_BEATS    = 100;
   localparam longint GAP_FACTOR     = 10;
   // 1e-6 rad/s expressed in Q(FRAC_BITS) LSBs, rounded up
   localparam longint VEL_ZERO_LSB   = ((longint'(1) << FRAC_BITS) + 999999) / 1000000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_payload_type      req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_payload_type      rsp_payload;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_data = '0;

   joint_command_slew_limiter_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always #CLOCK_HALF clock = ~clock;

   // Shadow of the block's registers and per-joint command memory
   bit                 cfg_write_enable = 1'b1;
   logic [13:0]        cfg_rate         = 14'd1000;
   logic [30:0]        cfg_max_step     = 31'd6554;
   logic [30:0]        cfg_max_speed    = 31'd65536;
   logic signed [31:0] prev_cmd [NUM_JOINTS];

   // Stimulus-side estimate of each joint's stored command, used to steer steps
   longint             gen_prev [NUM_JOINTS];

   req_payload_type    cmd_queue [$];     // beats waiting to be driven
   rsp_payload_type    expected_rsp [$];  // predicted results, oldest first
   rsp_payload_type    rsp_model;
   rsp_payload_type    rsp_want;

   int                 send_idle_pct = 17;
   int                 recv_idle_pct = 54;
   int                 mismatches    = 0;
   int                 quiet_cycles  = 0;

   // Move prev toward cmd by at most stp; flag when the step had to be cut.
   function automatic longint step_limit(input longint prev, input longint cmd,
                                         input longint stp, output bit hit);
      longint change;
      change = cmd - prev;
      hit    = (change > stp) || (change < -stp);
      if (change > stp)
         return prev + stp;
      if (change < -stp)
         return prev - stp;
      return cmd;
   endfunction

   // Work out the result of one accepted beat and update the command memory.
   function automatic bit slew_predict(input req_payload_type beat,
                                       output rsp_payload_type rsp);
      longint prev, cmd, meas, lim, vel, spd;
      bit     hit;
      rsp = '0;
      if (!cfg_write_enable || beat.joint_index >= NUM_JOINTS)
         return 1'b0;
      prev = longint'(prev_cmd[beat.joint_index]);
      cmd  = longint'($signed(beat.position_command));
      meas = longint'($signed(beat.measured_position));
      spd  = longint'(cfg_max_speed);
      lim  = step_limit(prev, cmd, longint'(cfg_max_step), hit);
      vel  = (lim - prev) * longint'(cfg_rate);
      // A velocity too small to matter falls back to chasing the measured gap
      if (vel < VEL_ZERO_LSB && vel > -VEL_ZERO_LSB)
         vel = GAP_FACTOR * (lim - meas);
      if (vel > spd)
         vel = spd;
      if (vel < -spd)
         vel = -spd;
      prev_cmd[beat.joint_index] = lim[31:0];
      rsp.joint_out        = beat.joint_index;
      rsp.limited_command  = lim[31:0];
      rsp.vel_target       = vel[31:0];
      rsp.step_was_limited = hit;
      return 1'b1;
   endfunction

   // Uniform value in [-span, span]; span may reach 2^31.
   function automatic longint rand_near(input longint span);
      longint raw;
      raw = longint'({$urandom, $urandom} >> 1);
      return raw % (2 * span + 1) - span;
   endfunction

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         mismatches++;
      end
   endtask

   // Driver: predict on every accepted beat, then load the next one or idle.
   // Valid and payload only change once the current beat is gone.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            if (slew_predict(req_payload, rsp_model))
               expected_rsp = {expected_rsp, rsp_model};
         end
         if (!req_valid || !req_stall) begin
            if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid   <= 1'b1;
               req_payload <= cmd_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each accepted result against the oldest prediction,
   // and stall the result channel at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               $display("%0t: result with nothing expected, expected none, actual %h",
                        $time, rsp_payload);
               mismatches++;
            end else begin
               rsp_want = expected_rsp.pop_front();
               compare_field("joint_out", 32'(rsp_want.joint_out),
                             32'(rsp_payload.joint_out));
               compare_field("limited_command", rsp_want.limited_command,
                             rsp_payload.limited_command);
               compare_field("vel_target", rsp_want.vel_target,
                             rsp_payload.vel_target);
               compare_field("step_was_limited", 32'(rsp_want.step_was_limited),
                             32'(rsp_payload.step_was_limited));
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Watchdog: end the run if no channel moves a beat for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic queue_beat(input int joint, input logic [31:0] cmd, input logic [31:0] meas);
      req_payload_type beat;
      beat.joint_index       = joint[2:0];
      beat.position_command  = cmd;
      beat.measured_position = meas;
      cmd_queue = {cmd_queue, beat};
   endtask

   // Hold until every beat is out and every result is back, then let the
   // pipeline empty of beats that produce nothing.
   task automatic drain();
      while (cmd_queue.size() != 0 || req_valid || expected_rsp.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One register write; leaves valid high so writes can go back to back.
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      case (idx)
         CSR_WRITE_ENABLE:    cfg_write_enable = data[0];
         CSR_CONTROL_RATE_HZ: cfg_rate         = data[13:0];
         CSR_MAX_STEP:        cfg_max_step     = data[30:0];
         CSR_MAX_SPEED:       cfg_max_speed    = data[30:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic [CSR_DAT_W-1:0] enable, input logic [CSR_DAT_W-1:0] rate,
                                 input logic [CSR_DAT_W-1:0] stp, input logic [CSR_DAT_W-1:0] spd);
      csr_write(CSR_WRITE_ENABLE, enable);
      csr_write(CSR_CONTROL_RATE_HZ, rate);
      csr_write(CSR_MAX_STEP, stp);
      csr_write(CSR_MAX_SPEED, spd);
      csr_valid <= 1'b0;
   endtask

   // Pick a setting with the extremes well represented; junk the unused upper bits.
   task automatic random_settings(input bit enable);
      logic [31:0] rate, stp, spd;
      case ($urandom_range(7))
         0:       rate = 0;
         1:       rate = 1;
         2:       rate = 10000;
         3:       rate = 16383;
         default: rate = $urandom_range(10000, 1);
      endcase
      case ($urandom_range(5))
         0:       stp = 0;
         1:       stp = 32'h7FFF_FFFF;
         default: stp = $urandom_range(1 << $urandom_range(20, 2));
      endcase
      case ($urandom_range(5))
         0:       spd = 0;
         1:       spd = 32'h7FFF_FFFF;
         default: spd = ($urandom >> 1) >> $urandom_range(20, 0);
      endcase
      apply_settings(($urandom & ~32'h1) | 32'(enable),
                     ($urandom & ~32'h3FFF) | rate,
                     ($urandom & 32'h8000_0000) | stp,
                     ($urandom & 32'h8000_0000) | spd);
   endtask

   // Random beats that mostly walk each joint near its stored command, so that
   // held steps, in-range steps and steps right at the limit all show up.
   task automatic queue_random(input int count);
      int              joint, pick;
      longint          stp, cmd, meas;
      bit              hit;
      req_payload_type beat;
      foreach (gen_prev[i])
         gen_prev[i] = longint'(prev_cmd[i]);
      stp = longint'(cfg_max_step);
      for (int n = 0; n < count; n++) begin
         joint = $urandom_range(NUM_JOINTS - 1);
         pick  = $urandom_range(99);
         if (pick < 20)
            cmd = gen_prev[joint];
         else if (pick < 60)
            cmd = gen_prev[joint] + rand_near(stp);
         else if (pick < 85)
            cmd = gen_prev[joint] + ($urandom_range(1) ? 1 : -1) *
                  (stp - 1 + longint'($urandom_range(2)));
         else
            cmd = longint'($signed($urandom));
         cmd = longint'($signed(cmd[31:0]));
         if ($urandom_range(9) < 7)
            meas = cmd + rand_near(4096);
         else
            meas = longint'($signed($urandom));
         beat.joint_index       = joint[2:0];
         beat.position_command  = cmd[31:0];
         beat.measured_position = meas[31:0];
         cmd_queue = {cmd_queue, beat};
         if (cfg_write_enable)
            gen_prev[joint] = step_limit(gen_prev[joint], cmd, stp, hit);
      end
   endtask

   initial begin
      foreach (prev_cmd[i])
         prev_cmd[i] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Register defaults from reset
      queue_beat(0, 1000, 0);                        // step in range
      queue_beat(0, 1000, -5000);                    // held step: measured gap
      queue_beat(1, 32'h7FFF_FFFF, 0);               // largest command, cut
      queue_beat(2, 32'h8000_0000, 32'h7FFF_FFFF);   // smallest command, cut
      queue_beat(3, 6554, 6554);                     // exactly max_step, not cut
      queue_beat(4, -6555, 0);                       // one past max_step down
      queue_beat(5, 0, 32'h7FFF_FFFF);               // gap saturates low
      queue_beat(6, 0, 32'h8000_0000);               // gap saturates high
      queue_beat(7, 0, 3);
      queue_beat(7, 0, 32'hFFFF_FFFF);
      queue_beat(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      drain();

      // Writes disabled (upper bits set, bit zero clear): no results, memory kept
      apply_settings(32'hFFFF_FFFE, 1000, 6554, 65536);
      queue_beat(0, 5000, 0);
      queue_beat(1, -100, 7);
      drain();

      // Zero control rate: velocity always falls back to the measured gap
      csr_write(CSR_SPARE_IDX, 32'hFFFF_FFFF);
      apply_settings(1, 0, 6554, 65536);
      queue_beat(0, 1000, 2000);
      queue_beat(0, 3000, 0);
      drain();

      // Rate above range, zero max_step, widest max_speed
      apply_settings(1, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF);
      queue_beat(0, 3001, 0);
      queue_beat(0, 3000, -100);
      drain();

      // Widest max_step: full-swing commands, velocity saturates both ways
      apply_settings(1, 16383, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
      queue_beat(2, 32'h7FFF_FFFF, 0);
      queue_beat(2, 32'h8000_0000, 0);
      drain();

      // Zero max_speed: velocity pinned at zero
      apply_settings(1, 1, 32'h7FFF_FFFF, 0);
      queue_beat(3, 100, 0);
      queue_beat(3, 100, 32'h8000_0000);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p < 4) begin
            send_idle_pct = 17;
            recv_idle_pct = 54;
         end else if (p < 7) begin
            send_idle_pct = 54;
            recv_idle_pct = 17;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (p == 5) begin
            // Short stretch with writes disabled in the middle of random traffic
            drain();
            random_settings(1'b0);
            queue_random(20);
         end
         drain();
         random_settings(1'b1);
         queue_random(PHASE_BEATS);
      end

      drain();
      if (mismatches == 0 && expected_rsp.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

>>> files.f
rtl/jcsl_pkg.sv
rtl/joint_command_slew_limiter_top.sv
dv/tb_top.sv
